@@ src/stf_pkg.sv @@
package stf_pkg;

   // Default number of learned sensor ID slots.
   localparam int SENSOR_SLOTS_DEF = 4;

   // Field widths of one request and one result.
   localparam int MODE_W      = 2;
   localparam int ID_W        = 32;
   localparam int PKT_W       = 8;
   localparam int SLOT_W      = 2;
   localparam int EXT_TIME_W  = 64;
   localparam int TIME_W      = 32;
   localparam int GAP_W       = 16;
   localparam int ID_MSB_W    = 8;

   // Request tdata layout, lowest bit first.
   localparam int REQ_ID_LSB   = 0;
   localparam int REQ_PKT_LSB  = REQ_ID_LSB + ID_W;
   localparam int REQ_SLOT_LSB = REQ_PKT_LSB + PKT_W;
   localparam int REQ_EXT_LSB  = REQ_SLOT_LSB + SLOT_W;
   localparam int REQ_DEV_BIT  = REQ_EXT_LSB + EXT_TIME_W;
   localparam int REQ_LRN_BIT  = REQ_DEV_BIT + 1;
   localparam int REQ_USED_W   = REQ_LRN_BIT + 1;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = MODE_W;

   // Result tdata layout, lowest bit first.
   localparam int RSP_FWD_BIT   = 0;
   localparam int RSP_STAMP_LSB = 1;
   localparam int RSP_MATCH_BIT = RSP_STAMP_LSB + TIME_W;
   localparam int RSP_SLOT_LSB  = RSP_MATCH_BIT + 1;
   localparam int RSP_USED_W    = RSP_SLOT_LSB + SLOT_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // Register write channel.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK     = 2'd0,
      MODE_SYNC     = 2'd1,
      MODE_TELEGRAM = 2'd2,
      MODE_LOAD_ID  = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ID_MSB_LOW  = 2'd0,
      CSR_ID_MSB_HIGH = 2'd1,
      CSR_MIN_GAP     = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

@@ src/stf_ctrl.sv @@
module stf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output stf_pkg::dp_cmd_type cmd
);
   import stf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The item is worked off once the result register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ src/stf_dpath.sv @@
module stf_dpath #(
   parameter int SENSOR_SLOTS = stf_pkg::SENSOR_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  stf_pkg::dp_cmd_type              cmd,
   input  logic [stf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [stf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                             csr_wr_en,
   input  logic [stf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stf_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [stf_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import stf_pkg::*;

   localparam int IDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

   // Configuration registers.
   logic [ID_MSB_W-1:0] id_msb_low_ff, id_msb_high_ff;
   logic [GAP_W-1:0]    min_gap_ff;

   // Captured request.
   mode_type              in_mode_ff;
   logic [ID_W-1:0]       in_id_ff;
   logic [PKT_W-1:0]      in_pkt_ff;
   logic [SLOT_W-1:0]     in_slot_ff;
   logic [EXT_TIME_W-1:0] in_ext_ff;
   logic                  in_dev_ff;
   logic                  in_learn_ff;

   // Block state.
   logic [ID_W-1:0]       learned_id_ff     [SENSOR_SLOTS];
   logic [SENSOR_SLOTS-1:0] slot_valid_ff;
   logic [TIME_W-1:0]     slot_last_time_ff [SENSOR_SLOTS];
   logic [PKT_W-1:0]      slot_last_pkt_ff  [SENSOR_SLOTS];
   logic [TIME_W-1:0]     local_time_ff, local_time_in;
   logic [EXT_TIME_W-1:0] sync_base_ff, sync_base_in;
   logic                  sync_seen_ff, sync_seen_in;

   // Result register.
   logic                  rsp_fwd_ff, rsp_match_ff;
   logic [TIME_W-1:0]     rsp_stamp_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;

   // Working signals.
   logic [SENSOR_SLOTS-1:0] hit_vec;
   logic                  hit_any;
   logic [IDX_W-1:0]      hit_sel;
   logic [SLOT_W-1:0]     hit_slot2;
   logic [TIME_W-1:0]     limit;
   logic                  fresh, in_range, bypass;
   logic                  fwd_in, match_in, upd_en;
   logic [SLOT_W-1:0]     mslot_in;
   logic [EXT_TIME_W-1:0] sync_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_msb_low_ff  <= '0;
         id_msb_high_ff <= '1;
         min_gap_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ID_MSB_LOW:  id_msb_low_ff  <= csr_data[ID_MSB_W-1:0];
            CSR_ID_MSB_HIGH: id_msb_high_ff <= csr_data[ID_MSB_W-1:0];
            CSR_MIN_GAP:     min_gap_ff     <= csr_data[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_mode_ff  <= mode_type'(req_tuser[MODE_W-1:0]);
         in_id_ff    <= req_tdata[REQ_ID_LSB +: ID_W];
         in_pkt_ff   <= req_tdata[REQ_PKT_LSB +: PKT_W];
         in_slot_ff  <= req_tdata[REQ_SLOT_LSB +: SLOT_W];
         in_ext_ff   <= req_tdata[REQ_EXT_LSB +: EXT_TIME_W];
         in_dev_ff   <= req_tdata[REQ_DEV_BIT];
         in_learn_ff <= req_tdata[REQ_LRN_BIT];
      end
   end

   // Parallel ID compare; the lowest matching slot wins.
   always_comb begin
      hit_sel   = '0;
      hit_slot2 = '0;
      for (int i = 0; i < SENSOR_SLOTS; i++) begin
         hit_vec[i] = slot_valid_ff[i] && (learned_id_ff[i] == in_id_ff);
      end
      for (int i = SENSOR_SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_sel   = IDX_W'(i);
            hit_slot2 = SLOT_W'(i);
         end
      end
      hit_any = |hit_vec;
   end

   assign limit    = slot_last_time_ff[hit_sel] + TIME_W'(min_gap_ff);
   assign fresh    = (local_time_ff > limit) || (in_pkt_ff != slot_last_pkt_ff[hit_sel]);
   assign in_range = (in_id_ff[ID_W-1 -: ID_MSB_W] >= id_msb_low_ff) &&
                     (in_id_ff[ID_W-1 -: ID_MSB_W] <= id_msb_high_ff);
   assign bypass   = in_dev_ff || !in_learn_ff;
   assign sync_diff = in_ext_ff - sync_base_ff;

   always_comb begin
      local_time_in = local_time_ff;
      sync_base_in  = sync_base_ff;
      sync_seen_in  = sync_seen_ff;
      fwd_in        = 1'b0;
      match_in      = 1'b0;
      mslot_in      = '0;
      upd_en        = 1'b0;
      case (in_mode_ff)
         MODE_TICK: local_time_in = local_time_ff + TIME_W'(1);
         MODE_SYNC: begin
            if (!sync_seen_ff) begin
               sync_seen_in  = 1'b1;
               sync_base_in  = in_ext_ff;
               local_time_in = '0;
            end else if (in_ext_ff > sync_base_ff) begin
               local_time_in = sync_diff[TIME_W-1:0];
            end
         end
         MODE_TELEGRAM: begin
            if (in_range) begin
               if (bypass) begin
                  fwd_in = 1'b1;
               end else if (hit_any) begin
                  match_in = 1'b1;
                  mslot_in = hit_slot2;
                  if (fresh) begin
                     fwd_in = 1'b1;
                     upd_en = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_time_ff <= '0;
         sync_base_ff  <= '0;
         sync_seen_ff  <= 1'b0;
      end else if (cmd.execute) begin
         local_time_ff <= local_time_in;
         sync_base_ff  <= sync_base_in;
         sync_seen_ff  <= sync_seen_in;
      end
   end

   for (genvar g = 0; g < SENSOR_SLOTS; g++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            learned_id_ff[g]     <= '0;
            slot_valid_ff[g]     <= 1'b0;
            slot_last_time_ff[g] <= '0;
            slot_last_pkt_ff[g]  <= '1;
         end else if (cmd.execute) begin
            if (in_mode_ff == MODE_LOAD_ID && 32'(in_slot_ff) == g) begin
               learned_id_ff[g] <= in_id_ff;
               slot_valid_ff[g] <= 1'b1;
            end
            if (upd_en && 32'(hit_sel) == g) begin
               slot_last_time_ff[g] <= local_time_ff;
               slot_last_pkt_ff[g]  <= in_pkt_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_fwd_ff   <= fwd_in;
         rsp_stamp_ff <= local_time_in;
         rsp_match_ff <= match_in;
         rsp_slot_ff  <= mslot_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_FWD_BIT]               = rsp_fwd_ff;
      rsp_tdata[RSP_STAMP_LSB +: TIME_W]   = rsp_stamp_ff;
      rsp_tdata[RSP_MATCH_BIT]             = rsp_match_ff;
      rsp_tdata[RSP_SLOT_LSB +: SLOT_W]    = rsp_slot_ff;
   end

endmodule

@@ src/sensor_telegram_repeat_filter_unit.sv @@
// A request transfer loads the input register; the execute state then fills the result
// register once it is free, and the unit stalls there while a result waits.
// Items are taken one at a time: the controller steps through its capture (idle) state
// and its execute state for each item before it takes the next request.
// Reset (synchronous, active high) clears the slot table, local time, the sync base
// and the registers to their defaults, and empties the result register.
module sensor_telegram_repeat_filter_unit #(
   parameter int SENSOR_SLOTS = stf_pkg::SENSOR_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: sensor_id[31:0], packet_id[39:32], slot[41:40], external_time[105:42],
   //        developer_mode[106], autolearn_done[107], zero fill up to bit 111.
   input  logic [stf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: mode[1:0] (tick, sync, telegram, load learned ID).
   input  logic [stf_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: forwarded[0], stamp[32:1], matched[33], match_slot[35:34],
   //        zero fill up to bit 39.
   output logic [stf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Register write channel; index 0 id_msb_low, 1 id_msb_high, 2 min_gap_ms.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [stf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import stf_pkg::*;

   dp_cmd_type cmd;

   // Register writes are always taken; writes to an unused index are dropped.
   assign csr_ready = 1'b1;

   // The controller sequences each item: a request transfer loads the input
   // register, then an execute step updates the state and fills the result
   // register as soon as the previous result has been transferred out.
   stf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds local time, the sync base, the slot table with its
   // parallel ID compare, the configuration registers and the result register.
   stf_dpath #(
      .SENSOR_SLOTS (SENSOR_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_wr_en (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ src/stf_checker.sv @@
module stf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [stf_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import stf_pkg::*;

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // One item at a time: no second request is taken in the cycle after a transfer.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // With a free result register, the result follows its request without a stall.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (!rsp_tvalid || rsp_tready) |=> ##1 rsp_tvalid)
      else $error("result missing after request transfer");

endmodule

bind sensor_telegram_repeat_filter_unit stf_checker u_stf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/tb_sensor_telegram_repeat_filter_unit.sv @@
module tb_sensor_telegram_repeat_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import stf_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int SLOTS          = SENSOR_SLOTS_DEF;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 154;
   // The unit answers from its result register after the execute state; the settle
   // time is plenty to be sure that nothing is still in flight.
   localparam int SETTLE_CYCLES  = 8;
   // Worst case is roughly 1300 items, each waiting out a long sender gap, a long
   // receiver stall and the capture and execute steps; this is several times that.
   localparam int CYCLE_LIMIT    = 600000;

   // One request as the sender sees it, fields at their port widths.
   typedef struct {
      mode_type           mode;
      logic [ID_W-1:0]    sensor_id;
      logic [PKT_W-1:0]   packet_id;
      logic [SLOT_W-1:0]  slot;
      logic [EXT_TIME_W-1:0] ext_time;
      logic               dev;
      logic               lrn;
   } telegram_item_type;

   // One result of the filter.
   typedef struct packed {
      logic               fwd;
      logic [TIME_W-1:0]  stamp;
      logic               matched;
      logic [SLOT_W-1:0]  mslot;
   } filter_result_type;

   // Clock and the single reset at the start of the run.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Inputs of the unit, all at known values from time zero.
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_W-1:0]      req_tdata  = '0;
   logic [REQ_TUSER_W-1:0]      req_tuser  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]      rsp_tdata;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index  = '0;
   logic [CSR_DATA_W-1:0]       csr_data   = '0;

   sensor_telegram_repeat_filter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Requests waiting to be sent, and the filter verdicts still owed by the unit.
   telegram_item_type  pending_q[$];
   filter_result_type  verdict_q[$];

   // The predictor's own copy of the registers, at their reset values.
   logic [ID_MSB_W-1:0] cfg_lo  = 8'h00;
   logic [ID_MSB_W-1:0] cfg_hi  = 8'hFF;
   logic [GAP_W-1:0]    cfg_gap = '0;

   // The predictor's own copy of the slot table and the time keeping.
   logic [ID_W-1:0]       slot_id_m   [SLOTS] = '{default: '0};
   logic                  slot_valid_m[SLOTS] = '{default: 1'b0};
   logic [TIME_W-1:0]     slot_time_m [SLOTS] = '{default: '0};
   logic [PKT_W-1:0]      slot_pkt_m  [SLOTS] = '{default: 8'hFF};
   logic [TIME_W-1:0]     local_time_m = '0;
   logic [EXT_TIME_W-1:0] sync_base_m  = '0;
   logic                  sync_seen_m  = 1'b0;

   // What the stimulus has already queued, so that random telegrams can aim at
   // IDs that will be in the table and syncs can land near the base.
   logic [ID_W-1:0]       gen_ids  [SLOTS] = '{default: '0};
   logic                  gen_valid[SLOTS] = '{default: 1'b0};
   logic                  gen_synced = 1'b0;
   logic [EXT_TIME_W-1:0] gen_base   = '0;

   // Bookkeeping for the driver, the monitor and the summary.
   telegram_item_type  req_item;
   filter_result_type  due_result;
   int req_gap     = 0;
   int req_calm    = 0;
   int rsp_stall   = 0;
   int rsp_calm    = 0;
   int cycle_count = 0;
   int rsp_count   = 0;
   int error_count = 0;
   int mode_count[4] = '{default: 0};
   int fwd_count   = 0;
   int match_count = 0;
   int drop_count  = 0;
   int reg_writes  = 0;

   // Prints one line per mismatch, up to a cap, and counts every one of them.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= 40) begin
         $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                  $time, rsp_count, what, got, want);
      end
   endtask

   // Gap length for either side: mostly none or short, now and then long, and
   // occasionally a calm stretch in which no gap is drawn at all.
   function automatic int draw_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Applies one accepted request to the predicted state and returns the
   // result the unit has to produce for it.
   function automatic filter_result_type predict_filter(telegram_item_type it);
      filter_result_type r;
      logic [ID_MSB_W-1:0] top;
      logic [TIME_W-1:0]   limit;
      int hit;
      int i;
      r = '0;
      hit = -1;
      mode_count[it.mode]++;
      case (it.mode)
         MODE_TICK: begin
            local_time_m = local_time_m + 1'b1;
         end
         MODE_SYNC: begin
            // The first sync takes the base and clears local time; later ones count
            // from it and are ignored unless they lie strictly above it.
            if (!sync_seen_m) begin
               sync_seen_m  = 1'b1;
               sync_base_m  = it.ext_time;
               local_time_m = '0;
            end else if (it.ext_time > sync_base_m) begin
               local_time_m = TIME_W'(it.ext_time - sync_base_m);
            end
         end
         MODE_LOAD_ID: begin
            // A load leaves the slot's last time and packet as they were.
            if (int'(it.slot) < SLOTS) begin
               slot_id_m[it.slot]    = it.sensor_id;
               slot_valid_m[it.slot] = 1'b1;
            end
         end
         default: begin
            top = it.sensor_id[ID_W-1 -: ID_MSB_W];
            if (top >= cfg_lo && top <= cfg_hi) begin
               if (it.dev || !it.lrn) begin
                  r.fwd = 1'b1;
               end else begin
                  // Lowest valid slot holding this ID wins.
                  for (i = SLOTS - 1; i >= 0; i--) begin
                     if (slot_valid_m[i] && slot_id_m[i] == it.sensor_id) hit = i;
                  end
                  if (hit >= 0) begin
                     limit     = slot_time_m[hit] + TIME_W'(cfg_gap);
                     r.matched = 1'b1;
                     r.mslot   = SLOT_W'(hit);
                     match_count++;
                     if (local_time_m > limit || it.packet_id != slot_pkt_m[hit]) begin
                        r.fwd            = 1'b1;
                        slot_time_m[hit] = local_time_m;
                        slot_pkt_m[hit]  = it.packet_id;
                     end else begin
                        drop_count++;
                     end
                  end
               end
            end
            if (r.fwd) fwd_count++;
         end
      endcase
      r.stamp = local_time_m;
      return r;
   endfunction

   // Queues one request and keeps the stimulus-side view of the table current.
   function automatic void add_item(mode_type m, logic [ID_W-1:0] id,
                                    logic [PKT_W-1:0] pkt, logic [SLOT_W-1:0] sl,
                                    logic [EXT_TIME_W-1:0] ext, logic dev, logic lrn);
      telegram_item_type it;
      it.mode      = m;
      it.sensor_id = id;
      it.packet_id = pkt;
      it.slot      = sl;
      it.ext_time  = ext;
      it.dev       = dev;
      it.lrn       = lrn;
      if (m == MODE_LOAD_ID) begin
         gen_ids[sl]   = id;
         gen_valid[sl] = 1'b1;
      end
      if (m == MODE_SYNC && !gen_synced) begin
         gen_synced = 1'b1;
         gen_base   = ext;
      end
      pending_q.push_back(it);
   endfunction

   // Blocks until every queued request has been sent and every result has come
   // back, then lets the unit settle. The check runs at the falling edge, when
   // the driver and the monitor have finished their work for the cycle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || verdict_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the predictor takes the new value once the transfer
   // has happened.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_ID_MSB_LOW:  cfg_lo  = value[ID_MSB_W-1:0];
         CSR_ID_MSB_HIGH: cfg_hi  = value[ID_MSB_W-1:0];
         CSR_MIN_GAP:     cfg_gap = value[GAP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_filter(logic [ID_MSB_W-1:0] lo, logic [ID_MSB_W-1:0] hi,
                                 logic [GAP_W-1:0] gap);
      write_reg(CSR_ID_MSB_LOW, CSR_DATA_W'(lo));
      write_reg(CSR_ID_MSB_HIGH, CSR_DATA_W'(hi));
      write_reg(CSR_MIN_GAP, gap);
   endtask

   // Request driver. A request is presented when the sender's gap has run out
   // and one is waiting; tvalid stays high across back-to-back transfers, and
   // every accepted request goes through the predictor at the edge of its
   // transfer, so the expected verdict is queued before the result can appear.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(predict_filter(req_item));
            req_gap = draw_gap(req_calm);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap == 0 && pending_q.size() != 0) begin
               req_item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               // tdata packing follows the port comment, lowest field first.
               req_tdata  <= {{(REQ_TDATA_W - REQ_USED_W){1'b0}}, req_item.lrn,
                              req_item.dev, req_item.ext_time, req_item.slot,
                              req_item.packet_id, req_item.sensor_id};
               req_tuser  <= req_item.mode;
            end else begin
               req_tvalid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end
         end
      end
   end

   // Result monitor. Each result transfer is checked field by field against the
   // oldest verdict still owed; ready is then held low for a random stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (verdict_q.size() == 0) begin
               report_mismatch("result with no verdict owed, tdata", 64'(rsp_tdata), '0);
            end else begin
               due_result = verdict_q.pop_front();
               if (rsp_tdata[RSP_FWD_BIT] !== due_result.fwd)
                  report_mismatch("forwarded", 64'(rsp_tdata[RSP_FWD_BIT]),
                                  64'(due_result.fwd));
               if (rsp_tdata[RSP_STAMP_LSB +: TIME_W] !== due_result.stamp)
                  report_mismatch("stamp", 64'(rsp_tdata[RSP_STAMP_LSB +: TIME_W]),
                                  64'(due_result.stamp));
               if (rsp_tdata[RSP_MATCH_BIT] !== due_result.matched)
                  report_mismatch("matched", 64'(rsp_tdata[RSP_MATCH_BIT]),
                                  64'(due_result.matched));
               if (rsp_tdata[RSP_SLOT_LSB +: SLOT_W] !== due_result.mslot)
                  report_mismatch("match_slot", 64'(rsp_tdata[RSP_SLOT_LSB +: SLOT_W]),
                                  64'(due_result.mslot));
            end
            rsp_stall = draw_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a run that has not finished by now is hung or lost a result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d verdicts still owed.",
                  cycle_count, verdict_q.size());
         $display("** sensor_telegram_repeat_filter_unit: FAILED **");
         $finish;
      end
   end

   // Stimulus: a directed part that walks the corner cases, then random phases,
   // each under its own register setting. Every phase boundary drains the unit
   // completely, so the sender regularly pauses until all results are in and the
   // registers are only ever written while the unit is idle.
   initial begin
      mode_type              m;
      logic [ID_W-1:0]       id;
      logic [PKT_W-1:0]      pkt;
      logic [SLOT_W-1:0]     sl;
      logic [EXT_TIME_W-1:0] ext;
      logic                  dev;
      logic                  lrn;
      logic [ID_MSB_W-1:0]   lo;
      logic [ID_MSB_W-1:0]   hi;
      logic [GAP_W-1:0]      gap;
      int                    roll;
      int                    k;
      int                    phase;
      int                    n;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // With the table empty a checked telegram cannot match; then both ways of
      // bypassing the table check.
      add_item(MODE_TELEGRAM, 32'hFFFF_FFFF, 8'hFF, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TELEGRAM, 32'h0000_0000, 8'h00, 2'd3, '1, 1'b1, 1'b1);
      add_item(MODE_TELEGRAM, 32'h1234_5678, 8'h07, 2'd0, '0, 1'b0, 1'b0);
      // The same ID in two slots, so the lower index has to win.
      add_item(MODE_LOAD_ID,  32'h1234_5678, 8'h00, 2'd0, '0, 1'b0, 1'b0);
      add_item(MODE_LOAD_ID,  32'h1234_5678, 8'h00, 2'd2, '0, 1'b0, 1'b0);
      add_item(MODE_LOAD_ID,  32'hFFFF_FFFF, 8'hFF, 2'd3, '1, 1'b1, 1'b1);
      // A packet equal to the slot's reset packet at time zero is a repeat; a new
      // packet passes, and so does the same packet once time has moved on.
      add_item(MODE_TELEGRAM, 32'h1234_5678, 8'hFF, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TELEGRAM, 32'h1234_5678, 8'h00, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TICK,     32'h0000_0000, 8'h00, 2'd0, '0, 1'b0, 1'b0);
      add_item(MODE_TELEGRAM, 32'h1234_5678, 8'h00, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TELEGRAM, 32'h1234_5678, 8'h00, 2'd0, '0, 1'b0, 1'b1);
      // First sync sets the base; a sync below or equal to it changes nothing; a
      // far larger one is cut to 32 bits, and the following tick wraps to zero.
      add_item(MODE_SYNC, 32'h0, 8'h00, 2'd0, 64'h0000_0001_0000_0000, 1'b0, 1'b0);
      add_item(MODE_SYNC, 32'h0, 8'h00, 2'd0, 64'h0000_0000_0000_0000, 1'b0, 1'b0);
      add_item(MODE_SYNC, 32'h0, 8'h00, 2'd0, 64'h0000_0001_0000_0000, 1'b0, 1'b0);
      add_item(MODE_SYNC, 32'h0, 8'h00, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      add_item(MODE_TELEGRAM, 32'hFFFF_FFFF, 8'h5A, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TICK,     32'h0000_0000, 8'h00, 2'd0, '0, 1'b0, 1'b0);
      wait_idle();

      // A one-value ID range: a matching repeat, and IDs just outside on both sides.
      program_filter(8'h12, 8'h12, 16'd5);
      add_item(MODE_TELEGRAM, 32'h1234_5678, 8'h00, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TELEGRAM, 32'h11FF_FFFF, 8'h01, 2'd0, '0, 1'b1, 1'b1);
      add_item(MODE_TELEGRAM, 32'h1300_0000, 8'h01, 2'd0, '0, 1'b1, 1'b1);
      wait_idle();

      // The largest gap on a slot stamped just before the wrap: its repeat limit
      // wraps around, so the same packet passes once, then repeats.
      program_filter(8'h00, 8'hFF, 16'hFFFF);
      add_item(MODE_SYNC, 32'h0, 8'h00, 2'd0, 64'h0000_0001_0001_0000, 1'b0, 1'b0);
      add_item(MODE_TELEGRAM, 32'hFFFF_FFFF, 8'h5A, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_TELEGRAM, 32'hFFFF_FFFF, 8'h5A, 2'd0, '0, 1'b0, 1'b1);
      add_item(MODE_LOAD_ID,  32'h0000_0000, 8'h00, 2'd1, '0, 1'b0, 1'b0);
      add_item(MODE_TELEGRAM, 32'h0000_0000, 8'h33, 2'd0, '0, 1'b0, 1'b1);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Fixed settings first (full range, largest gap, empty range, the top
         // and bottom byte alone), then random narrow ranges with small gaps.
         case (phase)
            0: begin lo = 8'h00; hi = 8'hFF; gap = 16'd0;     end
            1: begin lo = 8'h00; hi = 8'hFF; gap = 16'hFFFF;  end
            2: begin lo = 8'h90; hi = 8'h20; gap = 16'd3;     end
            3: begin lo = 8'hFF; hi = 8'hFF; gap = 16'd1;     end
            4: begin lo = 8'h00; hi = 8'h00; gap = 16'd10;    end
            default: begin
               lo  = 8'($urandom_range(0, 200));
               hi  = lo + 8'($urandom_range(0, 55));
               gap = 16'($urandom_range(0, 30));
            end
         endcase
         program_filter(lo, hi, gap);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Every field starts fully random, so each bit sees both values even
            // where the mode ignores it; the mode then shapes what matters.
            id   = $urandom();
            pkt  = 8'($urandom());
            sl   = 2'($urandom());
            ext  = {$urandom(), $urandom()};
            dev  = 1'($urandom());
            lrn  = 1'($urandom());
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               m = MODE_TICK;
            end else if (roll < 25) begin
               m = MODE_SYNC;
               roll = $urandom_range(0, 99);
               if (gen_synced && roll < 50)
                  ext = gen_base + 64'($urandom_range(0, 5000));
               else if (gen_synced && roll < 75)
                  ext = gen_base + 64'($urandom());
               else if (gen_synced && roll < 85)
                  ext = gen_base - 64'($urandom_range(1, 5000));
            end else if (roll < 35) begin
               m = MODE_LOAD_ID;
               if (lo <= hi && $urandom_range(0, 4) != 0)
                  id[ID_W-1 -: ID_MSB_W] = 8'($urandom_range(lo, hi));
            end else begin
               // Mostly well-formed telegrams from learned sensors with the table
               // check active and a small set of packet IDs, so that repeats,
               // gap expiry and slot updates all happen often.
               m = MODE_TELEGRAM;
               k = $urandom_range(0, SLOTS - 1);
               if ($urandom_range(0, 9) < 7 && gen_valid[k]) id = gen_ids[k];
               if ($urandom_range(0, 9) < 6) pkt = 8'($urandom_range(0, 3)) - 8'd1;
               dev = ($urandom_range(0, 9) == 0);
               lrn = ($urandom_range(0, 9) != 0);
            end
            add_item(m, id, pkt, sl, ext, dev, lrn);
         end
         wait_idle();
      end

      $display("Covered %0d ticks, %0d syncs, %0d telegrams and %0d ID loads over %0d results,",
               mode_count[MODE_TICK], mode_count[MODE_SYNC], mode_count[MODE_TELEGRAM],
               mode_count[MODE_LOAD_ID], rsp_count);
      $display("with %0d register writes; %0d telegrams forwarded, %0d matched, %0d repeats held.",
               reg_writes, fwd_count, match_count, drop_count);
      if (error_count == 0) begin
         $display("** sensor_telegram_repeat_filter_unit: PASSED **");
      end else begin
         $display("** sensor_telegram_repeat_filter_unit: FAILED **");
      end
      $finish;
   end

endmodule
